@@ rtl/rpdc_pkg.sv @@
// ============================================================================
// rpdc_pkg
// Shared types and constants for the radio packet deframer and checker.
// ============================================================================
package rpdc_pkg;

    // Default frame layout.
    localparam int IV_BYTES_DEF     = 16;
    localparam int HEADER_BYTES_DEF = 21;

    // Byte position counter saturates at its all-ones value.
    localparam int                 POS_W   = 9;
    localparam logic [POS_W-1:0]   POS_MAX = '1;

    // Fixed header positions.
    localparam logic [POS_W-1:0] POS_SYNC_A   = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC_B   = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH   = 9'd2;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 9'd3;
    localparam logic [POS_W-1:0] POS_NUMBER   = 9'd4;
    localparam int               FIRST_IV_POS = 5;

    // Sync bytes, the characters '#' and '0'.
    localparam logic [7:0] SYNC_A = 8'h23;
    localparam logic [7:0] SYNC_B = 8'h30;

    // Result kinds.
    localparam logic [1:0] KIND_IV      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Frame status codes.
    localparam logic [2:0] ST_GOOD       = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_LENGTH     = 3'd2;
    localparam logic [2:0] ST_CHECKSUM   = 3'd3;
    localparam logic [2:0] ST_DUPLICATE  = 3'd4;

    // Result queue geometry: one transfer may create two results.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [2:0] status_code;
        logic [7:0] missed_count;
        logic [7:0] frame_number;
        logic       last_of_run;
    } result_t;

endpackage

@@ rtl/radio_packet_deframer_checker.sv @@
// ============================================================================
// radio_packet_deframer_checker
// Splits received radio frames into IV and payload bytes and checks each frame.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | into      | in_valid, in_stall | rx_byte, frame_end
//  out     | out of    | out_valid,out_stall| kind, data_byte, status_code,
//          |           |                    | missed_count, frame_number,
//          |           |                    | last_of_run
//
// One byte is taken per cycle. The per-byte decode, checksum add and status
// decision are a single layer of logic from the frame state registers and the
// input ports into a four-entry result queue, so a result can be presented in
// the cycle after its byte is transferred. Sustained rate is one byte per cycle
// while each byte makes at most one result; a final byte that is also an IV or
// payload byte makes two results, and the output port, at one result per cycle,
// then sets the pace. The input stalls only when fewer than two queue entries
// are free. Reset empties the queue and clears all frame and sequence state.
// ============================================================================
module radio_packet_deframer_checker #(
    parameter int IV_BYTES     = rpdc_pkg::IV_BYTES_DEF,
    parameter int HEADER_BYTES = rpdc_pkg::HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic [2:0] status_code,
    output logic [7:0] missed_count,
    output logic [7:0] frame_number,
    output logic       last_of_run
);

    localparam int POS_W = rpdc_pkg::POS_W;

    // Frame state.
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       decl_len_reg;
    logic [7:0]       rx_sum_reg;
    logic [7:0]       run_sum_reg;
    logic [7:0]       number_reg;
    logic             hdr_bad_reg;
    // Sequence state, kept across frames.
    logic [7:0]       last_good_reg;
    logic             seen_first_reg;

    // Result queue.
    rpdc_pkg::result_t                  rq_mem [rpdc_pkg::RQ_DEPTH];
    logic [rpdc_pkg::RQ_PTR_W-1:0]      wr_ptr_reg;
    logic [rpdc_pkg::RQ_PTR_W-1:0]      rd_ptr_reg;
    logic [rpdc_pkg::RQ_CNT_W-1:0]      count_reg;

    logic in_take;
    logic out_take;

    // Byte decode.
    logic             is_iv;
    logic             is_payload;
    logic             is_summed;
    logic [7:0]       sum_add;
    logic [7:0]       sum_eff;
    logic [7:0]       decl_len_eff;
    logic [7:0]       rx_sum_eff;
    logic [7:0]       number_eff;
    logic             hdr_bad_eff;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W:0]   phys_len;
    logic [POS_W:0]   expect_len;

    // Status decision.
    logic [2:0]       status_sel;
    logic [7:0]       missed_sel;
    logic             is_dup;
    logic             is_gap;
    logic             good_frame;

    rpdc_pkg::result_t data_res;
    rpdc_pkg::result_t stat_res;
    rpdc_pkg::result_t res0;
    logic              push_two;
    logic              push_any;
    logic [1:0]        push_cnt;

    assign in_stall  = (count_reg > rpdc_pkg::RQ_CNT_W'(rpdc_pkg::RQ_DEPTH - 2));
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_take  = out_valid && !out_stall;

    // Position classes. The fixed header fields come first; positions between
    // the number and the end of the header are IV bytes while the IV lasts
    // and are otherwise skipped.
    always_comb
    begin
        is_payload = (pos_reg >= POS_W'(HEADER_BYTES));
        is_iv      = (pos_reg >= POS_W'(rpdc_pkg::FIRST_IV_POS))
                  && (pos_reg <  POS_W'(HEADER_BYTES))
                  && (pos_reg <  POS_W'(rpdc_pkg::FIRST_IV_POS + IV_BYTES));
        is_summed  = is_iv || is_payload || (pos_reg == rpdc_pkg::POS_NUMBER);
        sum_add    = run_sum_reg + rx_byte;
        sum_eff    = is_summed ? sum_add : run_sum_reg;

        decl_len_eff = (pos_reg == rpdc_pkg::POS_LENGTH)   ? rx_byte : decl_len_reg;
        rx_sum_eff   = (pos_reg == rpdc_pkg::POS_CHECKSUM) ? rx_byte : rx_sum_reg;
        number_eff   = (pos_reg == rpdc_pkg::POS_NUMBER)   ? rx_byte : number_reg;

        hdr_bad_eff = hdr_bad_reg;
        case (pos_reg)
            rpdc_pkg::POS_SYNC_A:
            begin
                if (rx_byte != rpdc_pkg::SYNC_A)
                    hdr_bad_eff = 1'b1;
            end
            rpdc_pkg::POS_SYNC_B:
            begin
                if (rx_byte != rpdc_pkg::SYNC_B)
                    hdr_bad_eff = 1'b1;
            end
            rpdc_pkg::POS_LENGTH:
            begin
                if (rx_byte == 8'd0)
                    hdr_bad_eff = 1'b1;
            end
            default:
            begin
                hdr_bad_eff = hdr_bad_reg;
            end
        endcase

        pos_inc    = (pos_reg == rpdc_pkg::POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
        phys_len   = {1'b0, pos_reg} + (POS_W+1)'(1);
        expect_len = {{(POS_W-7){1'b0}}, decl_len_eff} + (POS_W+1)'(HEADER_BYTES);
    end

    // Frame verdict, in order of priority. A stale or repeated number is
    // compared without wraparound; the first good frame after reset is taken
    // whatever its number.
    always_comb
    begin
        is_dup     = seen_first_reg && (number_eff <= last_good_reg);
        is_gap     = seen_first_reg && ({1'b0, number_eff} > ({1'b0, last_good_reg} + 9'd1));
        good_frame = 1'b0;
        missed_sel = 8'd0;
        if (hdr_bad_eff || (phys_len < (POS_W+1)'(HEADER_BYTES)))
            status_sel = rpdc_pkg::ST_BAD_HEADER;
        else if (phys_len != expect_len)
            status_sel = rpdc_pkg::ST_LENGTH;
        else if (sum_eff != rx_sum_eff)
            status_sel = rpdc_pkg::ST_CHECKSUM;
        else if (is_dup)
            status_sel = rpdc_pkg::ST_DUPLICATE;
        else
        begin
            status_sel = rpdc_pkg::ST_GOOD;
            good_frame = 1'b1;
            if (is_gap)
                missed_sel = number_eff - last_good_reg - 8'd1;
        end
    end

    always_comb
    begin
        data_res.kind         = is_iv ? rpdc_pkg::KIND_IV : rpdc_pkg::KIND_PAYLOAD;
        data_res.data_byte    = rx_byte;
        data_res.status_code  = rpdc_pkg::ST_GOOD;
        data_res.missed_count = 8'd0;
        data_res.frame_number = 8'd0;
        data_res.last_of_run  = !frame_end;

        stat_res.kind         = rpdc_pkg::KIND_STATUS;
        stat_res.data_byte    = 8'd0;
        stat_res.status_code  = status_sel;
        stat_res.missed_count = missed_sel;
        stat_res.frame_number = number_eff;
        stat_res.last_of_run  = 1'b1;

        push_two = (is_iv || is_payload) && frame_end;
        push_any = is_iv || is_payload || frame_end;
        res0     = (is_iv || is_payload) ? data_res : stat_res;
        push_cnt = in_take ? {push_two, push_any && !push_two} : 2'd0;
    end

    // Queue entries carry no reset; only the pointers and the count do.
    always_ff @(posedge clk)
    begin
        if (in_take && push_any)
            rq_mem[wr_ptr_reg] <= res0;
        if (in_take && push_two)
            rq_mem[wr_ptr_reg + rpdc_pkg::RQ_PTR_W'(1)] <= stat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + rpdc_pkg::RQ_PTR_W'(push_cnt);
            if (out_take)
                rd_ptr_reg <= rd_ptr_reg + rpdc_pkg::RQ_PTR_W'(1);
            count_reg <= count_reg + rpdc_pkg::RQ_CNT_W'(push_cnt)
                       - rpdc_pkg::RQ_CNT_W'(out_take);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            decl_len_reg   <= '0;
            rx_sum_reg     <= '0;
            run_sum_reg    <= '0;
            number_reg     <= '0;
            hdr_bad_reg    <= 1'b0;
            last_good_reg  <= '0;
            seen_first_reg <= 1'b0;
        end
        else if (in_take)
        begin
            if (frame_end)
            begin
                // Every per-frame item starts again from zero.
                pos_reg      <= '0;
                decl_len_reg <= '0;
                rx_sum_reg   <= '0;
                run_sum_reg  <= '0;
                number_reg   <= '0;
                hdr_bad_reg  <= 1'b0;
                if (good_frame)
                begin
                    last_good_reg  <= number_eff;
                    seen_first_reg <= 1'b1;
                end
            end
            else
            begin
                pos_reg      <= pos_inc;
                decl_len_reg <= decl_len_eff;
                rx_sum_reg   <= rx_sum_eff;
                run_sum_reg  <= sum_eff;
                number_reg   <= number_eff;
                hdr_bad_reg  <= hdr_bad_eff;
            end
        end
    end

    assign kind         = rq_mem[rd_ptr_reg].kind;
    assign data_byte    = rq_mem[rd_ptr_reg].data_byte;
    assign status_code  = rq_mem[rd_ptr_reg].status_code;
    assign missed_count = rq_mem[rd_ptr_reg].missed_count;
    assign frame_number = rq_mem[rd_ptr_reg].frame_number;
    assign last_of_run  = rq_mem[rd_ptr_reg].last_of_run;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rpdc_pkg::RQ_CNT_W'(rpdc_pkg::RQ_DEPTH))
        else $error("result queue count beyond its depth");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == rpdc_pkg::KIND_STATUS)) |-> last_of_run)
        else $error("frame status not marked as the last result");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != rpdc_pkg::KIND_STATUS))
            |-> ((status_code == rpdc_pkg::ST_GOOD) && (missed_count == 8'd0)))
        else $error("data result carries status fields");

    a_missed_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == rpdc_pkg::KIND_STATUS) && (missed_count != 8'd0))
            |-> (status_code == rpdc_pkg::ST_GOOD))
        else $error("missed count on a rejected frame");

    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && frame_end) |=> (pos_reg == '0))
        else $error("byte position not cleared after frame end");
`endif

endmodule
